// ===== hw/rtl/etc1_pkg.sv =====
// Shared types and constants for the ETC1 block decoder.
// No dependencies; imported by every module of the block.
package etc1_pkg;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int ROWS_PER_BLOCK = 4;
    localparam logic [1:0] LAST_ROW = 2'(ROWS_PER_BLOCK - 1);

    // Compressed block as it arrives.
    typedef struct packed {
        logic [31:0] colors_and_flags;
        logic [31:0] pixel_indices;
    } t_in;

    // One decoded row of four pixels.
    typedef struct packed {
        logic [1:0]  row;
        logic [23:0] pixel0_rgb;
        logic [23:0] pixel1_rgb;
        logic [23:0] pixel2_rgb;
        logic [23:0] pixel3_rgb;
        logic        last;
    } t_out;

    // Block after the front has classified it: both base colors at 8 bits
    // per channel, table codewords, split orientation, index planes.
    typedef struct packed {
        logic [23:0] base0;
        logic [23:0] base1;
        logic [2:0]  cw0;
        logic [2:0]  cw1;
        logic        flip;
        logic [15:0] idx_msb;
        logic [15:0] idx_lsb;
    } t_blk;

endpackage

// ===== hw/rtl/etc1_front.sv =====
// Front end: accepts compressed blocks and derives the base colors.
// Depends on etc1_pkg; feeds etc1_queue.
module etc1_front
    import etc1_pkg::*;
(
    input  logic i_valid,
    input  t_in  i_in,
    output logic o_stall,
    input  logic i_queue_full,
    output logic o_push,
    output t_blk o_blk
);

    logic [31:0] cf;
    logic        diff;
    logic [4:0]  r5, g5, b5;
    logic [4:0]  r5b, g5b, b5b;

    assign cf   = i_in.colors_and_flags;
    assign diff = cf[1];
    assign r5   = cf[31:27];
    assign g5   = cf[23:19];
    assign b5   = cf[15:11];

    // Base plus signed 3-bit delta, wrapping modulo 32.
    assign r5b = r5 + {{2{cf[26]}}, cf[26:24]};
    assign g5b = g5 + {{2{cf[18]}}, cf[18:16]};
    assign b5b = b5 + {{2{cf[10]}}, cf[10:8]};

    always_comb begin
        if (diff) begin
            o_blk.base0 = {r5, r5[4:2], g5, g5[4:2], b5, b5[4:2]};
            o_blk.base1 = {r5b, r5b[4:2], g5b, g5b[4:2], b5b, b5b[4:2]};
        end else begin
            o_blk.base0 = {cf[31:28], cf[31:28], cf[23:20], cf[23:20],
                           cf[15:12], cf[15:12]};
            o_blk.base1 = {cf[27:24], cf[27:24], cf[19:16], cf[19:16],
                           cf[11:8], cf[11:8]};
        end
        o_blk.cw0     = cf[7:5];
        o_blk.cw1     = cf[4:2];
        o_blk.flip    = cf[0];
        o_blk.idx_msb = i_in.pixel_indices[31:16];
        o_blk.idx_lsb = i_in.pixel_indices[15:0];
    end

    // Stall only while the queue is full; a transfer is a push.
    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

endmodule

// ===== hw/rtl/etc1_queue.sv =====
// Small FIFO of decoded blocks between front and back.
// Depends on etc1_pkg.
module etc1_queue
    import etc1_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_blk i_blk,
    input  logic i_pop,
    output logic o_full,
    output logic o_nonempty,
    output t_blk o_head
);

    t_blk                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;

    assign o_full     = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_blk;
        end
    end

endmodule

// ===== hw/rtl/etc1_back.sv =====
// Back end: walks the head block row by row, applies intensity modifiers
// and clamps, and holds each row in the output register. Uses etc1_pkg.
module etc1_back
    import etc1_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_head_valid,
    input  t_blk i_head,
    output logic o_pop,
    output logic o_valid,
    output t_out o_out,
    input  logic i_stall
);

    // Intensity modifier magnitude for a codeword and index LSB.
    function automatic logic [7:0] mod_mag(input logic [2:0] cw, input logic lsb);
        logic [7:0] val;
        case (cw)
            3'd0:    val = lsb ? 8'd8   : 8'd2;
            3'd1:    val = lsb ? 8'd17  : 8'd5;
            3'd2:    val = lsb ? 8'd29  : 8'd9;
            3'd3:    val = lsb ? 8'd42  : 8'd13;
            3'd4:    val = lsb ? 8'd60  : 8'd18;
            3'd5:    val = lsb ? 8'd80  : 8'd24;
            3'd6:    val = lsb ? 8'd106 : 8'd33;
            default: val = lsb ? 8'd183 : 8'd47;
        endcase
        return val;
    endfunction

    // Channel plus or minus magnitude, clamped to 0..255.
    function automatic logic [7:0] chan(input logic [7:0] b, input logic [7:0] m,
                                        input logic neg);
        logic [8:0] s;
        s = neg ? ({1'b0, b} - {1'b0, m}) : ({1'b0, b} + {1'b0, m});
        if (s[8]) begin
            return neg ? 8'h00 : 8'hFF;
        end
        return s[7:0];
    endfunction

    logic [1:0]  r_row;
    logic        r_valid;
    t_out        r_out;
    logic        load;
    logic [23:0] pix [ROWS_PER_BLOCK];
    logic [3:0]  k;
    logic        sub;
    logic [7:0]  mag;
    logic [23:0] base;

    always_comb begin
        for (int x = 0; x < ROWS_PER_BLOCK; x++) begin
            k    = {x[1:0], r_row};
            sub  = i_head.flip ? r_row[1] : x[1];
            mag  = mod_mag(sub ? i_head.cw1 : i_head.cw0, i_head.idx_lsb[k]);
            base = sub ? i_head.base1 : i_head.base0;
            pix[x] = {chan(base[23:16], mag, i_head.idx_msb[k]),
                      chan(base[15:8],  mag, i_head.idx_msb[k]),
                      chan(base[7:0],   mag, i_head.idx_msb[k])};
        end
    end

    // Output register takes a new row when empty or being drained.
    assign load  = i_head_valid && (!r_valid || !i_stall);
    assign o_pop = load && (r_row == LAST_ROW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_row   <= r_row + 1'b1;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.row        <= r_row;
            r_out.pixel0_rgb <= pix[0];
            r_out.pixel1_rgb <= pix[1];
            r_out.pixel2_rgb <= pix[2];
            r_out.pixel3_rgb <= pix[3];
            r_out.last       <= (r_row == LAST_ROW);
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

// ===== hw/rtl/etc1_block_decoder_core.sv =====
// ETC1 RGB8 block decoder, top level.
// Depends on etc1_pkg, etc1_front, etc1_queue and etc1_back.
//
// Usage:
//   Input channel (i_valid / o_stall / i_in): one 64-bit ETC1 block per
//   transfer, bytes 0..3 in colors_and_flags, bytes 4..7 in pixel_indices.
//   Output channel (o_valid / i_stall / o_out): four transfers per block,
//   rows 0..3 in order, four RGB888 pixels each; last marks row 3.
//   Row 0 is valid after the block passes the queue and the output register.
//   Throughput: one row per cycle while the queue holds a block and the
//   receiver does not stall, set by the back end's output register.
//   Front and back are decoupled by a 2-entry queue of decoded blocks: the
//   input is taken back to back while the queue has room, even while a
//   finished row waits in the output register. o_stall rises only with
//   the queue full.
//   When the receiver stalls, the current row holds steady in the output
//   register and the back end pauses; the queue then fills and the input
//   stalls in turn.
//   Reset (synchronous, active low) empties the queue, drops any pending
//   row and returns the row counter to 0; no clearing pass is needed.
module etc1_block_decoder_core
    import etc1_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_in,
    output logic o_stall,
    output logic o_valid,
    output t_out o_out,
    input  logic i_stall
);

    logic push;
    logic pop;
    logic queue_full;
    logic queue_nonempty;
    t_blk front_blk;
    t_blk head_blk;

    // Front: decode base colors and codewords, push into the queue.
    etc1_front u_front (
        .i_valid      (i_valid),
        .i_in         (i_in),
        .o_stall      (o_stall),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_blk        (front_blk)
    );

    // Queue of decoded blocks.
    etc1_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_blk      (front_blk),
        .i_pop      (pop),
        .o_full     (queue_full),
        .o_nonempty (queue_nonempty),
        .o_head     (head_blk)
    );

    // Back: one row per cycle from the head unless stalled; pops after row 3.
    etc1_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (queue_nonempty),
        .i_head       (head_blk),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_out        (o_out),
        .i_stall      (i_stall)
    );

endmodule

// ===== test/etc1_block_decoder_core_test.sv =====
// Self-checking testbench for the ETC1 block decoder core.
// Depends on etc1_pkg and etc1_block_decoder_core; rows are predicted in-line
// and compared field by field as they leave the block.
module etc1_block_decoder_core_test
    import etc1_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Run limits; the timeout, drain and settle limits are in clock cycles.
    localparam int TIMEOUT_CYCLES = 250000;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 20;
    localparam int RANDOM_BLOCKS  = 180;

    // Receiver stall patterns.
    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    t_in  i_in    = '0;
    logic i_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    t_out o_out;

    etc1_block_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_in    (i_in),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_out   (o_out),
        .i_stall (i_stall)
    );

    always #2 i_clk = ~i_clk;

    // Rows still owed by the block, oldest first.
    t_out        expected_rows[$];
    bit          failed;
    int          mismatch_count;

    // Sender and receiver idling controls, set per test.
    bit          sender_idles;
    int          burst_left;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_phase;

    // ------------------------------------------------------------------
    // Row predictor
    // ------------------------------------------------------------------

    // Magnitude of the intensity modifier: table row cw, small or large step.
    function automatic int modifier_mag(input logic [2:0] cw, input logic big);
        case (cw)
            3'd0:    return big ? 8   : 2;
            3'd1:    return big ? 17  : 5;
            3'd2:    return big ? 29  : 9;
            3'd3:    return big ? 42  : 13;
            3'd4:    return big ? 60  : 18;
            3'd5:    return big ? 80  : 24;
            3'd6:    return big ? 106 : 33;
            default: return big ? 183 : 47;
        endcase
    endfunction

    function automatic logic [7:0] ext4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic logic [7:0] ext5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    // Channel plus modifier, saturated to 0..255 on both sides.
    function automatic logic [7:0] clamp_channel(input logic [7:0] base, input int m);
        int s;
        s = int'(base) + m;
        if (s < 0)
            return 8'd0;
        if (s > 255)
            return 8'd255;
        return 8'(s);
    endfunction

    // Decodes one block into its four rows and queues them as expected.
    function automatic void decode_block_rows(input t_in blk);
        logic [31:0] cf;
        logic [31:0] idx;
        logic [23:0] base[2];
        logic [2:0]  cw[2];
        logic [4:0]  r5, g5, b5, r5b, g5b, b5b;
        logic [23:0] pix[4];
        t_out        row_out;
        int          k, m, sub;

        cf  = blk.colors_and_flags;
        idx = blk.pixel_indices;
        if (cf[1]) begin
            // Differential: 5-bit base, second color = base + signed delta, mod 32.
            r5  = cf[31:27];
            g5  = cf[23:19];
            b5  = cf[15:11];
            r5b = r5 + {{2{cf[26]}}, cf[26:24]};
            g5b = g5 + {{2{cf[18]}}, cf[18:16]};
            b5b = b5 + {{2{cf[10]}}, cf[10:8]};
            base[0] = {ext5(r5), ext5(g5), ext5(b5)};
            base[1] = {ext5(r5b), ext5(g5b), ext5(b5b)};
        end else begin
            base[0] = {ext4(cf[31:28]), ext4(cf[23:20]), ext4(cf[15:12])};
            base[1] = {ext4(cf[27:24]), ext4(cf[19:16]), ext4(cf[11:8])};
        end
        cw[0] = cf[7:5];
        cw[1] = cf[4:2];

        for (int y = 0; y < ROWS_PER_BLOCK; y++) begin
            for (int x = 0; x < 4; x++) begin
                k   = 4 * x + y;
                sub = cf[0] ? (y / 2) : (x / 2);
                m   = modifier_mag(cw[sub], idx[k]);
                if (idx[16 + k])
                    m = -m;
                pix[x] = {clamp_channel(base[sub][23:16], m),
                          clamp_channel(base[sub][15:8], m),
                          clamp_channel(base[sub][7:0], m)};
            end
            row_out.row        = 2'(y);
            row_out.pixel0_rgb = pix[0];
            row_out.pixel1_rgb = pix[1];
            row_out.pixel2_rgb = pix[2];
            row_out.pixel3_rgb = pix[3];
            row_out.last       = (2'(y) == LAST_ROW);
            expected_rows.push_back(row_out);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: one block per transfer; with sender_idles set, bursts are separated by random gaps
    // ------------------------------------------------------------------

    task automatic send_block(input t_in blk);
        i_valid <= 1'b1;
        i_in    <= blk;
        // Payload holds until the edge where the block is taken.
        do @(posedge i_clk); while (o_stall);
        decode_block_rows(blk);
        if (sender_idles) begin
            if (burst_left == 0) begin
                // Only assignment to i_valid in this step; the next send raises it.
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(0, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Fully random block; a quarter of them get saturated colors so both
    // clamp directions show up often.
    function automatic t_in random_block();
        t_in blk;
        blk.colors_and_flags = $urandom;
        blk.pixel_indices    = $urandom;
        if ($urandom_range(3) == 0)
            blk.colors_and_flags[31:8] = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
        return blk;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: stall pattern and row checker
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        case (stall_mode)
            STALL_NONE:     i_stall <= 1'b0;
            STALL_RANDOM:   i_stall <= ($urandom_range(99) < 30);
            STALL_HEAVY:    i_stall <= ($urandom_range(99) < 75);
            STALL_PERIODIC: i_stall <= ((stall_phase % 7) >= 4);
            default:        i_stall <= 1'b0;
        endcase
    end

    task automatic report_mismatch(input string field, input logic [23:0] want,
                                   input logic [23:0] got);
        failed = 1'b1;
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    // Values read here are the ones present at the edge, since every
    // driver updates with nonblocking assignments.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rows.size() == 0) begin
                failed = 1'b1;
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected row, expected none, actual %h", $time, o_out);
            end else begin
                want = expected_rows.pop_front();
                if (o_out.row !== want.row)
                    report_mismatch("row", 24'(want.row), 24'(o_out.row));
                if (o_out.pixel0_rgb !== want.pixel0_rgb)
                    report_mismatch("pixel0_rgb", want.pixel0_rgb, o_out.pixel0_rgb);
                if (o_out.pixel1_rgb !== want.pixel1_rgb)
                    report_mismatch("pixel1_rgb", want.pixel1_rgb, o_out.pixel1_rgb);
                if (o_out.pixel2_rgb !== want.pixel2_rgb)
                    report_mismatch("pixel2_rgb", want.pixel2_rgb, o_out.pixel2_rgb);
                if (o_out.pixel3_rgb !== want.pixel3_rgb)
                    report_mismatch("pixel3_rgb", want.pixel3_rgb, o_out.pixel3_rgb);
                if (o_out.last !== want.last)
                    report_mismatch("last", 24'(want.last), 24'(o_out.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, both modes, both split orientations, every codeword
    // on each sub-block, clamping at both ends and delta wrap both ways.
    task automatic test_directed_blocks();
        t_in        blk;
        logic [2:0] c;
        sender_idles = 1'b0;
        stall_mode   = STALL_NONE;

        // All zero: individual mode, smallest modifier everywhere.
        send_block('{32'h0000_0000, 32'h0000_0000});
        // All ones: differential, flipped, delta -1 on every channel.
        send_block('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
        // Black base, large negative steps: every channel clamps to 0.
        send_block('{32'h0000_00FC, 32'hFFFF_0000});
        // White base, largest positive step: every channel clamps to 255.
        send_block('{32'hFFFF_FFFC, 32'h0000_FFFF});
        // Differential, base 31 plus 3: wraps past the top.
        send_block('{32'hFBFB_FB02, 32'h1234_5678});
        // Differential, base 0 minus 4: wraps below zero.
        send_block('{32'h0404_0402, 32'h8765_4321});
        // Differential, mixed deltas, flipped.
        send_block('{32'h8A5D_2C03, 32'hAAAA_5555});
        // Alternating index planes in both orientations.
        send_block('{32'h3C96_E1A8, 32'h5555_AAAA});
        send_block('{32'h3C96_E1A9, 32'hAAAA_5555});
        send_block('{32'hC369_1E5A, 32'hF0F0_0F0F});
        send_block('{32'hC369_1E5B, 32'h0F0F_F0F0});

        // Every codeword on sub-block 1 against its mirror on sub-block 2.
        for (int i = 0; i < 8; i++) begin
            c = 3'(i);
            blk.colors_and_flags = {24'h7C3A95, c, 3'(7 - i), 1'b0, c[0]};
            blk.pixel_indices    = $urandom;
            send_block(blk);
        end
        for (int i = 0; i < 4; i++) begin
            c = 3'(i);
            blk.colors_and_flags = {24'h4A8F13, c, 3'(7 - i), 1'b1, c[1]};
            blk.pixel_indices    = $urandom;
            send_block(blk);
        end
    endtask

    // Full rate: no gaps and no stalls; the back end emits each block row by
    // row, so the queue fills and the input stalls between transfers.
    task automatic test_back_to_back_blocks();
        sender_idles = 1'b0;
        stall_mode   = STALL_NONE;
        repeat (40) send_block(random_block());
    endtask

    // Bulk random blocks, with the receiver pattern rotating every 50
    // transfers and stretches where the sender runs without gaps.
    task automatic test_random_blocks();
        for (int i = 0; i < RANDOM_BLOCKS; i++) begin
            if (i % 50 == 0) begin
                case ((i / 50) % 4)
                    0:       stall_mode = STALL_RANDOM;
                    1:       stall_mode = STALL_PERIODIC;
                    2:       stall_mode = STALL_NONE;
                    default: stall_mode = STALL_HEAVY;
                endcase
                sender_idles = ((i / 50) % 3 != 2);
            end
            send_block(random_block());
        end
    endtask

    // Receiver mostly stalled: rows must hold and the input must back up.
    task automatic test_receiver_backpressure();
        sender_idles = 1'b0;
        stall_mode   = STALL_HEAVY;
        repeat (30) send_block(random_block());
        stall_mode   = STALL_PERIODIC;
        repeat (30) send_block(random_block());
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        int waited;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_blocks();
        test_back_to_back_blocks();
        test_random_blocks();
        test_receiver_backpressure();

        // No more transfers; let the receiver take what is owed.
        i_valid    <= 1'b0;
        stall_mode  = STALL_RANDOM;
        waited      = 0;
        while (expected_rows.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        stall_mode = STALL_NONE;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (expected_rows.size() != 0) begin
            failed = 1'b1;
            $display("%0t: %0d rows never arrived, expected next %h, actual none",
                     $time, expected_rows.size(), expected_rows[0]);
        end

        if (failed)
            $display("tb: failure");
        else
            $display("tb: success");
        $finish;
    end

    // Hard stop if the handshake hangs.
    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/etc1_pkg.sv
hw/rtl/etc1_front.sv
hw/rtl/etc1_queue.sv
hw/rtl/etc1_back.sv
hw/rtl/etc1_block_decoder_core.sv
test/etc1_block_decoder_core_test.sv
